/* rtl/der_int_pkg.sv */
// ----------------------------------------------------------------------------
// DER INTEGER decoder package
// Shared types, constants and the header length function of the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package der_int_pkg;

  // Number of value bytes the decoded integer may hold.
  localparam int VALUE_BYTES = 8;
  localparam int VALUE_W     = 64;

  localparam int SEEN_W  = 33;
  localparam int DECL_W  = 32;
  localparam int COUNT_W = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 4'd10;
  localparam logic [COUNT_W-1:0] ACC_LIMIT  = COUNT_W'(VALUE_BYTES + 1);
  localparam logic [DECL_W-1:0]  WIDE_LIMIT = DECL_W'(VALUE_BYTES + 1);

  localparam logic [7:0] TAG_INTEGER   = 8'h02;
  localparam logic [7:0] LEN_LONG_MIN  = 8'h81;
  localparam logic [7:0] LEN_LONG_MAX  = 8'h84;
  localparam logic [2:0] HDR_SHORT_LEN = 3'd2;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_LEN_INVALID = 3'd1,
    ST_BUF_SHORT   = 3'd2,
    ST_WRONG_TAG   = 3'd3,
    ST_RANGE       = 3'd4
  } status_t;

  // Parser state of one buffer.
  typedef struct packed {
    logic [SEEN_W-1:0]  seen;
    logic [7:0]         form;
    logic [7:0]         tag;
    logic [DECL_W-1:0]  decl;
    logic [COUNT_W-1:0] count;
    logic [7:0]         first;
    logic [VALUE_W-1:0] acc;
  } der_state_t;

  // Header length (tag, length byte, long-form length bytes); zero when the
  // length byte is not a valid form.
  function automatic logic [2:0] hdr_len(input logic [7:0] form);
    logic [2:0] len;
    len = 3'd0;
    if (!form[7]) begin
      len = HDR_SHORT_LEN;
    end else if (form >= LEN_LONG_MIN && form <= LEN_LONG_MAX) begin
      len = form[2:0] + HDR_SHORT_LEN;
    end
    return len;
  endfunction

endpackage

/* rtl/der_int_parse.sv */
// ----------------------------------------------------------------------------
// DER INTEGER decoder parser
// Holds the per-buffer state and applies one buffer byte per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module der_int_parse (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [7:0]             data_byte,
  input  logic                   last,
  output der_int_pkg::der_state_t post
);

  der_int_pkg::der_state_t state_r;
  der_int_pkg::der_state_t state_nxt;
  logic [2:0]                       hdr_cur;
  logic [der_int_pkg::SEEN_W-1:0]   hdr_ext;
  logic [der_int_pkg::SEEN_W-1:0]   content_idx;

  assign hdr_cur     = der_int_pkg::hdr_len(state_r.form);
  assign hdr_ext     = der_int_pkg::SEEN_W'(hdr_cur);
  assign content_idx = state_r.seen - hdr_ext;

  always_comb begin
    state_nxt = state_r;
    if (state_r.seen == '0) begin
      state_nxt.tag = data_byte;
    end else if (state_r.seen == der_int_pkg::SEEN_W'(1)) begin
      state_nxt.form = data_byte;
      if (!data_byte[7]) begin
        state_nxt.decl = der_int_pkg::DECL_W'(data_byte);
      end
    end else if (hdr_cur > der_int_pkg::HDR_SHORT_LEN && state_r.seen < hdr_ext) begin
      state_nxt.decl = {state_r.decl[der_int_pkg::DECL_W-9:0], data_byte};
    end else if (hdr_cur != 3'd0 && state_r.seen >= hdr_ext &&
                 content_idx < {1'b0, state_r.decl}) begin
      if (state_r.count == '0) begin
        state_nxt.first = data_byte;
      end
      if (state_r.count < der_int_pkg::ACC_LIMIT) begin
        state_nxt.acc = {state_r.acc[der_int_pkg::VALUE_W-9:0], data_byte};
      end
      if (state_r.count < der_int_pkg::COUNT_MAX) begin
        state_nxt.count = state_r.count + 1'b1;
      end
    end
    // The byte counter saturates at all ones.
    if (state_r.seen != '1) begin
      state_nxt.seen = state_r.seen + 1'b1;
    end
  end

  assign post = state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (step) begin
      state_r <= last ? '0 : state_nxt;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && last |=> state_r == '0)
    else $error("parser state not cleared after last byte");

  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.count <= der_int_pkg::COUNT_MAX)
    else $error("content count passed its saturation point");

  a_seen_inc: assert property (@(posedge clk) disable iff (!rst_n)
    step && !last && state_r.seen != '1 |=> state_r.seen == $past(state_r.seen) + 1'b1)
    else $error("byte counter did not advance");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(state_r))
    else $error("parser state changed without a byte");

endmodule

/* rtl/der_int_check.sv */
// ----------------------------------------------------------------------------
// DER INTEGER decoder checker
// Evaluates the final parser state into a status and a decoded value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module der_int_check (
  input  der_int_pkg::der_state_t                post,
  output der_int_pkg::status_t                   status,
  output logic [der_int_pkg::VALUE_W-1:0]        value
);

  logic [2:0]                       hdr;
  logic [der_int_pkg::SEEN_W:0]     item_len;
  logic                             len_bad;
  logic                             too_wide;

  assign hdr      = der_int_pkg::hdr_len(post.form);
  assign item_len = (der_int_pkg::SEEN_W + 1)'(hdr) + (der_int_pkg::SEEN_W + 1)'(post.decl);
  assign len_bad  = post.seen < der_int_pkg::SEEN_W'(2) || hdr == 3'd0 ||
                    post.seen < der_int_pkg::SEEN_W'(hdr);
  assign too_wide = post.decl > der_int_pkg::WIDE_LIMIT ||
                    (post.decl == der_int_pkg::WIDE_LIMIT && post.first != 8'd0);

  // The checks are ordered; the first that fails sets the status.
  always_comb begin
    value = '0;
    priority if (len_bad) begin
      status = der_int_pkg::ST_LEN_INVALID;
    end else if (item_len > {1'b0, post.seen}) begin
      status = der_int_pkg::ST_BUF_SHORT;
    end else if (post.tag != der_int_pkg::TAG_INTEGER) begin
      status = der_int_pkg::ST_WRONG_TAG;
    end else if (post.decl != '0 && post.first[7]) begin
      status = der_int_pkg::ST_RANGE;
    end else if (too_wide) begin
      status = der_int_pkg::ST_RANGE;
    end else begin
      status = der_int_pkg::ST_OK;
      value  = (post.decl == '0) ? '0 : post.acc;
    end
  end

endmodule

/* rtl/der_integer_decoder_unit.sv */
// ----------------------------------------------------------------------------
// DER INTEGER decoder unit
// Decodes a DER INTEGER, one buffer byte per item, into a 64-bit unsigned value.
// ----------------------------------------------------------------------------
// Usage: the sender presents one byte of the DER buffer per input item on
// in_data_byte, with in_buffer_end high on the last byte of the buffer. An
// item moves when in_valid is high and in_stall is low. Every byte is taken
// by a small register update, so it accepts one item per cycle unless stalled.
// Only the last byte of a buffer yields a result item: out_status and
// out_decoded_value, moved when out_valid is high and out_stall is low. The
// value is zero unless the status is ok. Bytes after the encoded item are
// ignored, and the next buffer starts with the byte after the flagged one.
// An input item is captured in the input register at the accepting edge,
// and the result of a final byte is loaded into the output register once
// that register is free. The rate of one item per cycle, outside stalls, is
// set by the parser update between the two registers.
// When the receiver stalls, a pending result holds; the unit keeps taking
// bytes that yield no result, and raises in_stall only when a final byte
// waits for the output register. A synchronous reset (rst_n low) drops any
// items in flight and clears the parser state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module der_integer_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_buffer_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [63:0] out_decoded_value
);

  // Input register stage.
  logic       s1_valid_r;
  logic [7:0] s1_data_r;
  logic       s1_last_r;

  // Output register stage.
  logic                                out_valid_r;
  der_int_pkg::status_t                out_status_r;
  logic [der_int_pkg::VALUE_W-1:0]     out_value_r;

  logic                                out_free;
  logic                                s1_go;
  logic                                in_take;
  logic                                res_load;
  der_int_pkg::der_state_t             post;
  der_int_pkg::status_t                chk_status;
  logic [der_int_pkg::VALUE_W-1:0]     chk_value;

  // The output register is free when empty or being drained this cycle.
  assign out_free = !out_valid_r || !out_stall;
  // A byte without the end flag never needs the output register.
  assign s1_go    = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;
  assign res_load = s1_go && s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_buffer_end;
    end
  end

  der_int_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_go),
    .data_byte (s1_data_r),
    .last      (s1_last_r),
    .post      (post)
  );

  der_int_check u_check (
    .post   (post),
    .status (chk_status),
    .value  (chk_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status_r <= chk_status;
      out_value_r  <= chk_value;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_decoded_value = out_value_r;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with an empty input register");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_last_r && !in_stall |=> out_valid)
    else $error("final byte produced no result");

  a_value_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != der_int_pkg::ST_OK |-> out_decoded_value == '0)
    else $error("nonzero value with an error status");

endmodule
